// ----- design/multipass_box_blur_line_defines.svh -----
// assertion macros used by the multipass box blur line back end
// no dependencies, expects a clock named clk and a reset named rst in scope
`ifndef MULTIPASS_BOX_BLUR_LINE_DEFINES_SVH
`define MULTIPASS_BOX_BLUR_LINE_DEFINES_SVH

// condition holds at every edge out of reset
`define MBBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// trigger implies a consequence in the following cycle
`define MBBL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- design/mbbl_pkg.sv -----
// shared types, constants and tables for the multipass box blur line
// no dependencies
package mbbl_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int MAX_PASSES  = 3;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_MAX     = 2 * MAX_RADIUS + 1;
  localparam int MEM_DEPTH   = MAX_PASSES * WIN_MAX;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int SUM_W       = 21;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PADDR_W     = 3;

  typedef struct packed {
    logic [15:0] sample_in;
    logic        row_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sample_out;
    logic        row_end;
    logic        run_end;
  } out_item_t;

  typedef enum logic {
    KIND_MID,
    KIND_ROW_END
  } kind_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    kind_t                  kind;
  } work_item_t;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_PASSES = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_OUT,
    ST_NEXT,
    ST_DONE
  } state_t;

  // ceil(2^26 / (2r+1)), exact quotient for any 21-bit dividend
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      4'd0:    m = 27'd67108864;
      4'd1:    m = 27'd22369622;
      4'd2:    m = 27'd13421773;
      4'd3:    m = 27'd9586981;
      4'd4:    m = 27'd7456541;
      4'd5:    m = 27'd6100806;
      4'd6:    m = 27'd5162221;
      4'd7:    m = 27'd4473925;
      4'd8:    m = 27'd3947581;
      4'd9:    m = 27'd3532046;
      4'd10:   m = 27'd3195661;
      4'd11:   m = 27'd2917777;
      4'd12:   m = 27'd2684355;
      4'd13:   m = 27'd2485514;
      4'd14:   m = 27'd2314099;
      4'd15:   m = 27'd2164803;
      default: m = 27'd67108864;
    endcase
    return m;
  endfunction

endpackage

// ----- design/mbbl_front.sv -----
// input side: two-entry queue that takes beats and tags row ends
// depends on mbbl_pkg
module mbbl_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  mbbl_pkg::in_item_t   in_data,
  output logic                 in_stall,
  input  logic                 pop,
  output logic                 q_valid,
  output mbbl_pkg::work_item_t q_item
);
  import mbbl_pkg::*;

  work_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign take     = pop && q_valid;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].sample <= in_data.sample_in[SAMPLE_BITS-1:0];
      slot[wr_ptr].kind   <= in_data.row_last ? KIND_ROW_END : KIND_MID;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end
endmodule

// ----- design/mbbl_back.sv -----
// back end: sequencer running each sample through the cascaded passes
// depends on mbbl_pkg and multipass_box_blur_line_defines.svh
`include "multipass_box_blur_line_defines.svh"

module mbbl_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic [3:0]           blur_radius,
  input  logic [1:0]           pass_count,
  input  logic                 q_valid,
  input  mbbl_pkg::work_item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  output mbbl_pkg::out_item_t  out_data,
  input  logic                 out_stall
);
  import mbbl_pkg::*;

  typedef struct packed {
    logic pop;
    logic rd;
    logic sum;
    logic mul;
    logic chain;
    logic final_res;
    logic step;
    logic done;
  } ctl_t;

  state_t state, state_next;
  ctl_t   ctl;

  logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata;

  logic [SUM_W-1:0]       sum   [MAX_PASSES];
  logic [4:0]             fill  [MAX_PASSES];
  logic [4:0]             pos   [MAX_PASSES];
  logic                   wrapped [MAX_PASSES];
  logic [SAMPLE_BITS-1:0] first [MAX_PASSES];
  logic [SAMPLE_BITS-1:0] lasts [MAX_PASSES];

  logic [1:0]             p;
  logic [SAMPLE_BITS-1:0] v;
  logic                   last_item;
  logic                   flushing;
  logic                   fstarted;
  logic [1:0]             fp;
  logic [3:0]             left;
  logic [SUM_W-1:0]       dividend;
  logic [SAMPLE_BITS-1:0] q;
  logic                   hold_valid;
  logic [SAMPLE_BITS-1:0] hold_val;

  logic [4:0]             len;
  logic [MEM_AW-1:0]      addr;
  logic [SAMPLE_BITS-1:0] old;
  logic [SUM_W-1:0]       sum_new;
  logic [4:0]             fill_new;
  logic [4:0]             pos_inc;
  logic                   due;
  logic                   more_pass;
  logic                   out_free;
  logic [SUM_W+RECIP_W-1:0] prod;

  assign len       = {blur_radius, 1'b1};
  assign addr      = MEM_AW'(p) * MEM_AW'(WIN_MAX) + MEM_AW'(pos[p]);
  assign old       = wrapped[p] ? rdata : first[p];
  assign pos_inc   = pos[p] + 5'd1;
  assign more_pass = ({1'b0, p} + 3'd1) < {1'b0, pass_count};
  assign out_free  = !out_valid || !out_stall;
  assign prod      = (SUM_W+RECIP_W)'(dividend) * (SUM_W+RECIP_W)'(recip(blur_radius));

  always_comb begin
    if (fill[p] == 5'd0) begin
      sum_new  = SUM_W'(len) * SUM_W'(v);
      fill_new = {1'b0, blur_radius} + 5'd1;
    end else begin
      sum_new  = sum[p] + SUM_W'(v) - SUM_W'(old);
      fill_new = (fill[p] < len) ? fill[p] + 5'd1 : fill[p];
    end
    due = (fill_new >= len);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) state_next = (pass_count == 2'd0) ? ST_OUT : ST_READ;
      ST_READ: state_next = ST_SUM;
      ST_SUM:  state_next = due ? ST_MUL : ST_NEXT;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT: begin
        if (more_pass) state_next = ST_READ;
        else if (!hold_valid || out_free) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (!last_item) state_next = ST_DONE;
        else if (flushing && fp >= pass_count) state_next = ST_DONE;
        else if (flushing && fstarted && left != 4'd0) state_next = ST_READ;
      end
      ST_DONE: if (!hold_valid || out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: ctl.pop = q_valid;
      ST_READ: ctl.rd  = 1'b1;
      ST_SUM:  ctl.sum = 1'b1;
      ST_MUL:  ctl.mul = 1'b1;
      ST_OUT: begin
        ctl.chain     = more_pass;
        ctl.final_res = !more_pass && (!hold_valid || out_free);
      end
      ST_NEXT: ctl.step = 1'b1;
      ST_DONE: ctl.done = hold_valid && out_free;
      default: ctl = '0;
    endcase
  end

  assign pop = ctl.pop;

  always_ff @(posedge clk) begin
    if (ctl.rd) rdata <= mem[addr];
    if (ctl.sum && fill[p] != 5'd0) mem[addr] <= v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAX_PASSES; i++) fill[i] <= 5'd0;
    end else begin
      state <= state_next;

      // a new beat leaves on a done or when a held result is pushed out
      if (ctl.done || (ctl.final_res && hold_valid)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (ctl.pop) begin
        v         <= q_item.sample;
        q         <= q_item.sample;
        p         <= 2'd0;
        last_item <= (q_item.kind == KIND_ROW_END);
        flushing  <= 1'b0;
      end

      if (ctl.sum) begin
        sum[p]   <= sum_new;
        fill[p]  <= fill_new;
        lasts[p] <= v;
        dividend <= sum_new + (p[0] ? SUM_W'(0) : SUM_W'({blur_radius, 1'b0}));
        if (fill[p] == 5'd0) begin
          first[p]   <= v;
          pos[p]     <= 5'd0;
          wrapped[p] <= 1'b0;
        end else if (pos_inc == len) begin
          pos[p]     <= 5'd0;
          wrapped[p] <= 1'b1;
        end else begin
          pos[p] <= pos_inc;
        end
      end

      if (ctl.mul) q <= prod[RECIP_SHIFT +: SAMPLE_BITS];

      if (ctl.chain) begin
        v <= q;
        p <= p + 2'd1;
      end

      if (ctl.final_res) begin
        if (hold_valid) begin
          out_data <= '{sample_out: hold_val, row_end: 1'b0, run_end: 1'b0};
        end
        hold_valid <= 1'b1;
        hold_val   <= q;
      end

      if (ctl.step && last_item) begin
        if (!flushing) begin
          flushing <= 1'b1;
          fp       <= 2'd0;
          fstarted <= 1'b0;
        end else if (fp < pass_count) begin
          if (!fstarted) begin
            fstarted <= 1'b1;
            left     <= (fill[fp] != 5'd0) ? blur_radius : 4'd0;
          end else if (left != 4'd0) begin
            left <= left - 4'd1;
            v    <= lasts[fp];
            p    <= fp;
          end else begin
            fill[fp] <= 5'd0;
            fp       <= fp + 2'd1;
            fstarted <= 1'b0;
          end
        end
      end

      if (ctl.done) begin
        out_data   <= '{sample_out: hold_val, row_end: last_item, run_end: 1'b1};
        hold_valid <= 1'b0;
      end

      if (clear) begin
        for (int i = 0; i < MAX_PASSES; i++) fill[i] <= 5'd0;
      end
    end
  end

  `MBBL_ASSERT(a_row_end_closes_run, !(out_valid && out_data.row_end) || out_data.run_end, "row end without run end")
  `MBBL_ASSERT(a_fill_bounded, fill[0] <= len, "fill count beyond window")
  `MBBL_ASSERT(a_pos_in_ring, fill[0] == 5'd0 || pos[0] < len, "ring position outside window")
  `MBBL_ASSERT_NEXT(a_done_to_idle, state == ST_DONE && !hold_valid, state == ST_IDLE, "done did not return to idle")

endmodule

// ----- design/multipass_box_blur_line.sv -----
// per item: the queue, then for each pass that yields a result the read, sum, multiply and out
// states; a pass still filling its window ends the cascade after sum; with no passes a sample
// goes from idle straight to out. row end: each non-empty pass replays its last sample radius times
// the sequencer takes one item at a time and waits on output stalls; the queue holds two
// reset (rst, synchronous): radius 1, one pass, all passes empty, queue and output cleared
// the window memory is never cleared, entries are read only after written within a row
module multipass_box_blur_line (
  input  logic                         clk,
  input  logic                         rst,
  // sample stream in
  input  logic                         in_valid,
  input  mbbl_pkg::in_item_t           in_data,
  output logic                         in_stall,
  // blurred stream out
  output logic                         out_valid,
  output mbbl_pkg::out_item_t          out_data,
  input  logic                         out_stall,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbbl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mbbl_pkg::*;

  logic       [3:0] blur_radius;
  logic       [1:0] pass_count;
  logic             cfg_wr;
  reg_idx_t         reg_sel;
  logic             q_valid;
  work_item_t       q_item;
  logic             pop;

  // register writes land in the access phase, pready is tied high
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_radius <= 4'd1;
      pass_count  <= 2'd1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_RADIUS: blur_radius <= pwdata[3:0];
        REG_PASSES: pass_count  <= pwdata[1:0];
        default:    blur_radius <= blur_radius;
      endcase
    end
  end

  // readback of the selected register
  always_comb begin
    case (reg_sel)
      REG_RADIUS: prdata = {28'd0, blur_radius};
      REG_PASSES: prdata = {30'd0, pass_count};
      default:    prdata = 32'd0;
    endcase
  end

  // front queue absorbs beats while the sequencer works
  mbbl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // sequencer, window memory and output register; any register write drops the row
  mbbl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .clear       (cfg_wr),
    .blur_radius (blur_radius),
    .pass_count  (pass_count),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );
endmodule
